### rtl/core/b2da_pkg.sv
package b2da_pkg;

  localparam int VALUE_W      = 32;
  localparam int MAG_W        = VALUE_W - 1;
  localparam int VALUE_DIGITS = 10;
  localparam int DIGIT_IDX_W  = $clog2(VALUE_DIGITS);
  localparam int MAX_DIGITS   = 10;
  localparam int SHIFT_CNT_W  = $clog2(MAG_W);
  localparam int CHAR_W       = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);

  typedef logic [VALUE_DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

### rtl/core/b2da_dabble.sv
module b2da_dabble (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [b2da_pkg::MAG_W-1:0]   mag,
  output logic                         done,
  output b2da_pkg::bcd_t               bcd
);

  logic                                busy;
  logic [b2da_pkg::SHIFT_CNT_W-1:0]    count;
  logic [b2da_pkg::MAG_W-1:0]          shreg;
  b2da_pkg::bcd_t                      adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < b2da_pkg::VALUE_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == b2da_pkg::SHIFT_CNT_W'(b2da_pkg::MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= mag;
      bcd   <= '0;
    end else if (busy) begin
      {bcd, shreg} <= {adj, shreg} << 1;
    end
  end

endmodule

### rtl/core/binary_to_decimal_ascii_core.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  value (32 bits, signed)
// out      output     out_valid / out_ready digit_char (6 bits), last_digit
//
// A non-negative value runs through the bit-serial shift-and-add-three converter,
// then the leading-zero scan and the digit beats, before the core is ready again.
// A negative value is accepted and dropped, with no digits sent.
// Reset is synchronous and clears the sequencer and the output valid.
// A stalled out channel holds the sequencer in the digit phase; the final beat
// waits in the output register while the next value is accepted.
module binary_to_decimal_ascii_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [b2da_pkg::VALUE_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]   digit_char,
  output logic                          last_digit
);

  b2da_pkg::state_t                    state, state_next;
  logic [b2da_pkg::DIGIT_IDX_W-1:0]    ptr, ptr_next;
  logic                                seen, seen_next;
  logic                                out_valid_next;
  logic                                load_out;
  logic                                start;
  logic                                done;
  b2da_pkg::bcd_t                      bcd;
  logic [3:0]                          cur;
  logic                                nz;

  b2da_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mag   (value[b2da_pkg::MAG_W-1:0]),
    .done  (done),
    .bcd   (bcd)
  );

  assign cur = bcd[ptr];
  assign nz  = (cur != 4'd0);

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    seen_next      = seen;
    in_ready       = 1'b0;
    start          = 1'b0;
    load_out       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      b2da_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !value[b2da_pkg::VALUE_W-1]) begin
          start      = 1'b1;
          state_next = b2da_pkg::ST_CONVERT;
        end
      end
      b2da_pkg::ST_CONVERT: begin
        if (done) begin
          ptr_next   = b2da_pkg::DIGIT_IDX_W'(b2da_pkg::VALUE_DIGITS - 1);
          seen_next  = 1'b0;
          state_next = b2da_pkg::ST_SCAN;
        end
      end
      b2da_pkg::ST_SCAN: begin
        // skip leading zeros and digits beyond the kept width
        if (ptr != '0 && (32'(ptr) >= b2da_pkg::MAX_DIGITS || (!seen && !nz))) begin
          ptr_next  = ptr - 1'b1;
          seen_next = seen | nz;
        end else begin
          state_next = b2da_pkg::ST_EMIT;
        end
      end
      b2da_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          if (ptr == '0) begin
            state_next = b2da_pkg::ST_IDLE;
          end else begin
            ptr_next = ptr - 1'b1;
          end
        end
      end
      default: begin
        state_next = b2da_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= b2da_pkg::ST_IDLE;
      out_valid <= 1'b0;
      ptr       <= '0;
      seen      <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      ptr       <= ptr_next;
      seen      <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      digit_char <= b2da_pkg::CHAR_ZERO | {{(b2da_pkg::CHAR_W - 4){1'b0}}, cur};
      last_digit <= (ptr == '0);
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_VALUES = 400;
  localparam int TAIL_CYCLES   = 60;
  localparam int DIR_ROWS      = 20;
  localparam int TEXT_W        = 8 * b2da_pkg::VALUE_DIGITS;

  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } digit_beat_t;

  // typed rows carry the printed number right-aligned, blank bytes as zero
  typedef struct packed {
    logic signed [b2da_pkg::VALUE_W-1:0] num;
    logic                                typed;
    logic [TEXT_W-1:0]                   text;
  } dir_row_t;

  logic                                clk        = 1'b0;
  logic                                rst        = 1'b1;
  logic                                in_valid   = 1'b0;
  logic                                in_ready;
  logic signed [b2da_pkg::VALUE_W-1:0] value      = '0;
  logic                                out_valid;
  logic                                out_ready  = 1'b0;
  logic [b2da_pkg::CHAR_W-1:0]         digit_char;
  logic                                last_digit;

  logic                                typed_on   = 1'b0;
  logic [TEXT_W-1:0]                   typed_text = '0;

  int send_idle_pct  = 16;
  int recv_stall_pct = 54;
  int errors         = 0;
  int cycles         = 0;

  digit_beat_t pending_digits[$];
  dir_row_t    dir_rows[DIR_ROWS];

  binary_to_decimal_ascii_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void push_decimal_digits(logic signed [b2da_pkg::VALUE_W-1:0] v);
    logic [3:0]                   digs[b2da_pkg::VALUE_DIGITS];
    logic [b2da_pkg::VALUE_W-1:0] mag;
    int                           n;
    int                           keep;
    digit_beat_t                  b;
    n   = 0;
    mag = v;
    if (v < 0) return;
    if (v == 0) begin
      b.ch   = b2da_pkg::CHAR_ZERO;
      b.last = 1'b1;
      pending_digits.push_back(b);
      return;
    end
    while (mag != 0 && n < b2da_pkg::VALUE_DIGITS) begin
      digs[n] = 4'(mag % 10);
      mag     = mag / 10;
      n++;
    end
    // only the least significant digits survive a short buffer
    keep = (n > b2da_pkg::MAX_DIGITS) ? b2da_pkg::MAX_DIGITS : n;
    for (int k = keep - 1; k >= 0; k--) begin
      b.ch   = b2da_pkg::CHAR_ZERO + b2da_pkg::CHAR_W'(digs[k]);
      b.last = (k == 0);
      pending_digits.push_back(b);
    end
  endfunction

  function automatic void push_typed_digits(logic [TEXT_W-1:0] text);
    digit_beat_t b;
    for (int i = b2da_pkg::VALUE_DIGITS - 1; i >= 0; i--) begin
      if (text[8*i +: 8] != 8'h00) begin
        b.ch   = text[8*i +: b2da_pkg::CHAR_W];
        b.last = (i == 0);
        pending_digits.push_back(b);
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    digit_beat_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (typed_on) push_typed_digits(typed_text);
        else push_decimal_digits(value);
      end
      if (out_valid && out_ready) begin
        if (pending_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char 0x%0h last %0b",
                                    digit_char, last_digit));
        end else begin
          want = pending_digits.pop_front();
          if (digit_char !== want.ch)
            report_mismatch($sformatf("digit_char 0x%0h, want 0x%0h", digit_char, want.ch));
          if (last_digit !== want.last)
            report_mismatch($sformatf("last_digit %0b, want %0b", last_digit, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("binary_to_decimal_ascii_core regression: fail");
      $finish;
    end
  end

  task automatic send_value(logic signed [b2da_pkg::VALUE_W-1:0] v, logic typed,
                            logic [TEXT_W-1:0] text);
    int gap;
    gap = 0;
    // now and then a long gap, so valid rises at any point of the conversion
    if (send_idle_pct > 0 && $urandom_range(0, 9) == 0) gap = $urandom_range(0, 60);
    else while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    value      <= v;
    typed_on   <= typed;
    typed_text <= text;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_digits.size() != 0);
  endtask

  initial begin
    logic signed [b2da_pkg::VALUE_W-1:0] v;
    logic [b2da_pkg::VALUE_W-1:0]        p;
    int                                  productive;
    int                                  phase;
    dir_rows = '{
      '{32'sd0,           1'b1, "0"},
      '{32'sd9,           1'b1, "9"},
      '{32'sh7fff_ffff,   1'b1, "2147483647"},
      '{-32'sd1,          1'b1, '0},
      '{32'sh8000_0000,   1'b1, '0},
      '{32'sd1000000000,  1'b1, "1000000000"},
      '{32'sd999999999,   1'b1, "999999999"},
      '{32'sd1,           1'b0, '0},
      '{32'sd10,          1'b0, '0},
      '{32'sd99,          1'b0, '0},
      '{32'sd100,         1'b0, '0},
      '{32'sd101,         1'b0, '0},
      '{32'sd42,          1'b0, '0},
      '{32'sd65535,       1'b0, '0},
      '{32'sd1234567890,  1'b0, '0},
      '{32'sh5555_5555,   1'b0, '0},
      '{32'sh2aaa_aaaa,   1'b0, '0},
      '{32'sh7fff_fffe,   1'b0, '0},
      '{-32'sd5,          1'b0, '0},
      '{32'sd0,           1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_value(dir_rows[i].num, dir_rows[i].typed, dir_rows[i].text);
    hold_until_drained();

    productive = 0;
    while (productive < RANDOM_VALUES) begin
      phase = productive * 3 / RANDOM_VALUES;
      // swap the idling pattern at each third, letting the pipe empty first
      if (phase == 1 && send_idle_pct != 54) begin
        hold_until_drained();
        send_idle_pct  = 54;
        recv_stall_pct = 16;
      end else if (phase == 2 && send_idle_pct != 0) begin
        hold_until_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case ($urandom_range(0, 9))
        0: v = {1'b1, 31'($urandom)};
        1: v = $urandom_range(0, 9);
        2: v = $urandom_range(0, 999);
        3: begin
          p = 1;
          repeat ($urandom_range(1, 9)) p = p * 10;
          v = p - 1 + $urandom_range(0, 2);
        end
        4: v = $urandom_range(0, 65535);
        default: v = {1'b0, 31'($urandom)};
      endcase
      if (v >= 0) productive++;
      send_value(v, 1'b0, '0);
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("binary_to_decimal_ascii_core regression: pass");
    end else begin
      $display("binary_to_decimal_ascii_core regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/b2da_pkg.sv
rtl/core/b2da_dabble.sv
rtl/core/binary_to_decimal_ascii_core.sv
verif/testbench.sv
